>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file rpt_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low)
`define RPT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Clocked assertion that also holds during reset
`define RPT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/rpt_pkg.sv
// Package for the rotary encoder position tracker: constants, types, decode functions.
// No dependencies.
package rpt_pkg;

    // Number of acceleration tiers
    localparam int TIER_COUNT = 3;

    // Timing constants
    localparam logic [31:0] DEBOUNCE_US = 32'd20000;
    localparam logic [9:0]  US_PER_MS   = 10'd1000;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_POSITION   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_POSITION   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_ENABLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_DIR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_DETENT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TIER_THRESH    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TIER_MULT      = 3'd7;

    // Register reset values
    localparam logic [31:0] MIN_POS_RESET   = 32'd0;
    localparam logic [31:0] MAX_POS_RESET   = 32'd100;
    localparam logic [30:0] STEP_RESET      = 31'd1;
    localparam logic [47:0] THRESH_RESET    = 48'd171803934870;
    localparam logic [47:0] MULT_RESET      = 48'd214749347845;

    // Saturation limits, 34-bit signed sum domain
    localparam logic signed [33:0] SUM_MAX = 34'sh0_7FFF_FFFF;
    localparam logic signed [33:0] SUM_MIN = {2'b11, 32'h8000_0000};
    localparam logic [30:0]        EFF_MAX = 31'h7FFF_FFFF;

    // Serial remainder unit
    localparam int MOD_W = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TIER,
        ST_MULT,
        ST_ADD,
        ST_FIT,
        ST_MOD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [MOD_W-1:0] dividend;
        logic [MOD_W:0]   divisor;
    } mod_req_t;

    typedef struct packed {
        logic             done;
        logic [MOD_W-1:0] remainder;
    } mod_rsp_t;

    // Quadrature transition decode, index = {old_phase, new_phase}
    function automatic logic signed [1:0] phase_dir(input logic [3:0] idx);
        logic signed [1:0] d;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14: d = 2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: d = -2'sd1;
            default: d = 2'sd0;
        endcase
        return d;
    endfunction

    // 16-bit field k of a packed tier register; fields past the third read zero
    function automatic logic [15:0] field16(input logic [47:0] v, input logic [1:0] k);
        logic [15:0] f;
        case (k)
            2'd0: f = v[15:0];
            2'd1: f = v[31:16];
            2'd2: f = v[47:32];
            default: f = 16'd0;
        endcase
        return f;
    endfunction

endpackage

>>> hw/rtl/rotary_encoder_position_tracker.sv
// Top level of the rotary encoder position tracker.
// Depends on rpt_pkg and rpt_mod_unit.

// Takes one pin-sample or reset request at a time. Quadrature decode, step
// counting and button debounce finish in the accept cycle; a request that
// completes no detent, and a reset request, has its result registered in the
// output state once the output register is free. A detent runs a sequencer:
// tier search (one threshold compare per cycle, highest tier first), the step
// multiply, the saturating add and the range check, in that order. When
// wrapping carries the position past a limit, the serial remainder unit runs
// its 32 subtract steps before the result. A result that waits on m_ready
// does not block the next request. The block is ready immediately after reset.
module rotary_encoder_position_tracker #(
    parameter int TIER_COUNT = rpt_pkg::TIER_COUNT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration writes
    input  logic                             cfg_wr_en,
    input  logic [rpt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rpt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Sample requests
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_command,
    input  logic                             s_a_level,
    input  logic                             s_b_level,
    input  logic                             s_button_level,
    input  logic [31:0]                      s_now_us,
    // Results
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [31:0]               m_position,
    output logic [1:0]                       m_active_tier,
    output logic                             m_button_pressed
);

    localparam int KW = (TIER_COUNT > 1) ? $clog2(TIER_COUNT) : 1;

    // Configuration registers
    logic signed [31:0] min_pos_reg;
    logic signed [31:0] max_pos_reg;
    logic [30:0]        step_size_reg;
    logic               wrap_en_reg;
    logic               reverse_reg;
    logic               half_det_reg;
    logic [47:0]        thresh_reg;
    logic [47:0]        mult_cfg_reg;

    // Tracker state
    rpt_pkg::state_t    state_reg, state_next;
    logic [1:0]         last_phase_reg, last_phase_next;
    logic signed [3:0]  step_cnt_reg, step_cnt_next;
    logic signed [31:0] held_pos_reg, held_pos_next;
    logic [31:0]        last_det_reg, last_det_next;
    logic [1:0]         held_tier_reg, held_tier_next;
    logic               stable_btn_reg, stable_btn_next;
    logic               pressed_reg, pressed_next;
    logic [31:0]        db_start_reg, db_start_next;
    logic               db_run_reg, db_run_next;

    // Detent datapath
    logic [31:0]        diff_reg, diff_next;
    logic               dir_up_reg, dir_up_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [15:0]        mult_reg, mult_next;
    logic [46:0]        prod_reg, prod_next;
    logic signed [31:0] pos_reg, pos_next;
    logic               above_reg, above_next;

    // Output register
    logic               m_valid_reg, m_valid_next;
    logic signed [31:0] m_pos_reg, m_pos_next;
    logic [1:0]         m_tier_reg, m_tier_next;
    logic               m_pressed_reg, m_pressed_next;

    rpt_pkg::mod_req_t  mod_req;
    rpt_pkg::mod_rsp_t  mod_rsp;

    logic accept;
    logic out_free;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Quadrature decode and step count, evaluated on the accepted request
    logic [1:0]        phase;
    logic              phase_chg;
    logic signed [1:0] dir_raw;
    logic signed [1:0] dir_eff;
    logic signed [3:0] cnt_sum;
    logic signed [3:0] spd;
    logic              detent;

    assign phase     = {~s_a_level, ~s_b_level};
    assign phase_chg = (phase != last_phase_reg);
    assign dir_raw   = rpt_pkg::phase_dir({last_phase_reg, phase});
    assign dir_eff   = reverse_reg ? -dir_raw : dir_raw;
    assign cnt_sum   = step_cnt_reg + {{2{dir_eff[1]}}, dir_eff};
    assign spd       = half_det_reg ? 4'sd2 : 4'sd4;
    assign detent    = phase_chg && (dir_raw != 2'sd0) && ((cnt_sum >= spd) || (cnt_sum <= -spd));

    // Tier compare: floor(diff / 1000) < th  <=>  diff < th * 1000
    logic [15:0] tier_th;
    logic [25:0] tier_th_us;
    logic        tier_hit;
    logic [1:0]  k_ext;

    assign k_ext      = 2'(k_reg);
    assign tier_th    = rpt_pkg::field16(thresh_reg, k_ext);
    assign tier_th_us = 26'(tier_th) * 26'(rpt_pkg::US_PER_MS);
    assign tier_hit   = (tier_th != 16'd0) && (diff_reg < {6'd0, tier_th_us});

    // Saturating position add
    logic [30:0]        eff;
    logic signed [33:0] held_ext;
    logic signed [33:0] eff_ext;
    logic signed [33:0] sum;

    assign eff      = (prod_reg > {16'd0, rpt_pkg::EFF_MAX}) ? rpt_pkg::EFF_MAX : prod_reg[30:0];
    assign held_ext = {{2{held_pos_reg[31]}}, held_pos_reg};
    assign eff_ext  = {3'd0, eff};
    assign sum      = dir_up_reg ? (held_ext + eff_ext) : (held_ext - eff_ext);

    // Range check
    logic signed [33:0] lo_ext;
    logic signed [33:0] hi_ext;
    logic signed [33:0] pos_ext;
    logic               pos_above;
    logic               pos_below;
    logic               wrap_ok;
    logic signed [33:0] dvd_above;
    logic signed [33:0] dvd_below;
    logic signed [33:0] range_ext;
    logic signed [33:0] wrap_lo;
    logic signed [33:0] wrap_hi;

    assign lo_ext    = {{2{min_pos_reg[31]}}, min_pos_reg};
    assign hi_ext    = {{2{max_pos_reg[31]}}, max_pos_reg};
    assign pos_ext   = {{2{pos_reg[31]}}, pos_reg};
    assign pos_above = pos_ext > hi_ext;
    assign pos_below = pos_ext < lo_ext;
    assign wrap_ok   = wrap_en_reg && !(hi_ext < lo_ext);
    assign dvd_above = pos_ext - lo_ext;
    assign dvd_below = lo_ext - 34'sd1 - pos_ext;
    assign range_ext = hi_ext - lo_ext + 34'sd1;
    assign wrap_lo   = lo_ext + {2'd0, mod_rsp.remainder};
    assign wrap_hi   = hi_ext - {2'd0, mod_rsp.remainder};

    rpt_mod_unit u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .rsp     (mod_rsp)
    );

    // Next-state logic
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rpt_pkg::ST_IDLE: begin
                if (accept) begin
                    if (!s_command && detent) begin
                        state_next = rpt_pkg::ST_TIER;
                    end else begin
                        state_next = rpt_pkg::ST_OUT;
                    end
                end
            end
            rpt_pkg::ST_TIER: begin
                if (tier_hit || (k_reg == '0)) begin
                    state_next = rpt_pkg::ST_MULT;
                end
            end
            rpt_pkg::ST_MULT: state_next = rpt_pkg::ST_ADD;
            rpt_pkg::ST_ADD:  state_next = rpt_pkg::ST_FIT;
            rpt_pkg::ST_FIT: begin
                if (wrap_ok && (pos_above || pos_below)) begin
                    state_next = rpt_pkg::ST_MOD;
                end else begin
                    state_next = rpt_pkg::ST_OUT;
                end
            end
            rpt_pkg::ST_MOD: begin
                if (mod_rsp.done) begin
                    state_next = rpt_pkg::ST_OUT;
                end
            end
            rpt_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = rpt_pkg::ST_IDLE;
                end
            end
            default: state_next = rpt_pkg::ST_IDLE;
        endcase
    end

    // Output and datapath logic
    always_comb begin
        s_ready          = (state_reg == rpt_pkg::ST_IDLE);
        mod_req.start    = 1'b0;
        mod_req.dividend = pos_above ? dvd_above[31:0] : dvd_below[31:0];
        mod_req.divisor  = range_ext[32:0];

        last_phase_next = last_phase_reg;
        step_cnt_next   = step_cnt_reg;
        held_pos_next   = held_pos_reg;
        last_det_next   = last_det_reg;
        held_tier_next  = held_tier_reg;
        stable_btn_next = stable_btn_reg;
        pressed_next    = pressed_reg;
        db_start_next   = db_start_reg;
        db_run_next     = db_run_reg;
        diff_next       = diff_reg;
        dir_up_next     = dir_up_reg;
        k_next          = k_reg;
        mult_next       = mult_reg;
        prod_next       = prod_reg;
        pos_next        = pos_reg;
        above_next      = above_reg;

        m_valid_next    = m_valid_reg && !m_ready;
        m_pos_next      = m_pos_reg;
        m_tier_next     = m_tier_reg;
        m_pressed_next  = m_pressed_reg;

        case (state_reg)
            rpt_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_command) begin
                        // reset request: position to min, tier cleared
                        held_pos_next  = min_pos_reg;
                        held_tier_next = 2'd0;
                    end else begin
                        // rotation
                        if (phase_chg) begin
                            last_phase_next = phase;
                            if (dir_raw == 2'sd0 || detent) begin
                                step_cnt_next = 4'sd0;
                            end else begin
                                step_cnt_next = cnt_sum;
                            end
                        end
                        if (detent) begin
                            diff_next     = s_now_us - last_det_reg;
                            last_det_next = s_now_us;
                            dir_up_next   = (cnt_sum > 4'sd0);
                            k_next        = KW'(TIER_COUNT - 1);
                        end
                        // button first-edge debounce
                        if (s_button_level != stable_btn_reg) begin
                            if (!db_run_reg) begin
                                db_start_next = s_now_us;
                                db_run_next   = 1'b1;
                            end else if ((s_now_us - db_start_reg) >= rpt_pkg::DEBOUNCE_US) begin
                                stable_btn_next = s_button_level;
                                db_run_next     = 1'b0;
                                pressed_next    = !s_button_level;
                            end
                        end else begin
                            db_run_next = 1'b0;
                        end
                    end
                end
            end
            rpt_pkg::ST_TIER: begin
                if (tier_hit) begin
                    held_tier_next = 2'(k_ext + 2'd1);
                    mult_next      = rpt_pkg::field16(mult_cfg_reg, k_ext);
                end else if (k_reg == '0) begin
                    held_tier_next = 2'd0;
                    mult_next      = 16'd1;
                end else begin
                    k_next = k_reg - 1'b1;
                end
            end
            rpt_pkg::ST_MULT: begin
                prod_next = 47'(step_size_reg) * 47'(mult_reg);
            end
            rpt_pkg::ST_ADD: begin
                if (sum > rpt_pkg::SUM_MAX) begin
                    pos_next = rpt_pkg::SUM_MAX[31:0];
                end else if (sum < rpt_pkg::SUM_MIN) begin
                    pos_next = rpt_pkg::SUM_MIN[31:0];
                end else begin
                    pos_next = sum[31:0];
                end
            end
            rpt_pkg::ST_FIT: begin
                above_next = pos_above;
                if (wrap_ok && (pos_above || pos_below)) begin
                    mod_req.start = 1'b1;
                end else if (pos_below) begin
                    held_pos_next = min_pos_reg;
                end else if (pos_above) begin
                    held_pos_next = max_pos_reg;
                end else begin
                    held_pos_next = pos_reg;
                end
            end
            rpt_pkg::ST_MOD: begin
                if (mod_rsp.done) begin
                    held_pos_next = above_reg ? wrap_lo[31:0] : wrap_hi[31:0];
                end
            end
            rpt_pkg::ST_OUT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_pos_next     = held_pos_reg;
                    m_tier_next    = held_tier_reg;
                    m_pressed_next = pressed_reg;
                end
            end
            default: ;
        endcase
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_pos_reg   <= rpt_pkg::MIN_POS_RESET;
            max_pos_reg   <= rpt_pkg::MAX_POS_RESET;
            step_size_reg <= rpt_pkg::STEP_RESET;
            wrap_en_reg   <= 1'b0;
            reverse_reg   <= 1'b0;
            half_det_reg  <= 1'b0;
            thresh_reg    <= rpt_pkg::THRESH_RESET;
            mult_cfg_reg  <= rpt_pkg::MULT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rpt_pkg::REG_MIN_POSITION: min_pos_reg   <= cfg_wdata[31:0];
                rpt_pkg::REG_MAX_POSITION: max_pos_reg   <= cfg_wdata[31:0];
                rpt_pkg::REG_STEP_SIZE:    step_size_reg <= cfg_wdata[30:0];
                rpt_pkg::REG_WRAP_ENABLE:  wrap_en_reg   <= cfg_wdata[0];
                rpt_pkg::REG_REVERSE_DIR:  reverse_reg   <= cfg_wdata[0];
                rpt_pkg::REG_HALF_DETENT:  half_det_reg  <= cfg_wdata[0];
                rpt_pkg::REG_TIER_THRESH:  thresh_reg    <= cfg_wdata[47:0];
                rpt_pkg::REG_TIER_MULT:    mult_cfg_reg  <= cfg_wdata[47:0];
                default: ;
            endcase
        end
    end

    // Tracker state and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= rpt_pkg::ST_IDLE;
            last_phase_reg <= 2'd0;
            step_cnt_reg   <= 4'sd0;
            held_pos_reg   <= 32'sd0;
            last_det_reg   <= 32'd0;
            held_tier_reg  <= 2'd0;
            stable_btn_reg <= 1'b1;
            pressed_reg    <= 1'b0;
            db_start_reg   <= 32'd0;
            db_run_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            last_phase_reg <= last_phase_next;
            step_cnt_reg   <= step_cnt_next;
            held_pos_reg   <= held_pos_next;
            last_det_reg   <= last_det_next;
            held_tier_reg  <= held_tier_next;
            stable_btn_reg <= stable_btn_next;
            pressed_reg    <= pressed_next;
            db_start_reg   <= db_start_next;
            db_run_reg     <= db_run_next;
            m_valid_reg    <= m_valid_next;
        end
        diff_reg      <= diff_next;
        dir_up_reg    <= dir_up_next;
        k_reg         <= k_next;
        mult_reg      <= mult_next;
        prod_reg      <= prod_next;
        pos_reg       <= pos_next;
        above_reg     <= above_next;
        m_pos_reg     <= m_pos_next;
        m_tier_reg    <= m_tier_next;
        m_pressed_reg <= m_pressed_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_position       = m_pos_reg;
    assign m_active_tier    = m_tier_reg;
    assign m_button_pressed = m_pressed_reg;

endmodule

>>> hw/rtl/rpt_mod_unit.sv
// Restoring serial remainder unit, one quotient bit per cycle.
// Depends on rpt_pkg.
module rpt_mod_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  rpt_pkg::mod_req_t req,
    output rpt_pkg::mod_rsp_t rsp
);

    localparam int W     = rpt_pkg::MOD_W;
    localparam int CNT_W = $clog2(W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W:0]       rem_reg, rem_next;
    logic [W-1:0]     dvd_reg, dvd_next;
    logic [W:0]       div_reg, div_next;

    logic [W+1:0] trial;
    logic [W+1:0] trial_sub;

    // Shift in next dividend bit and try the subtraction
    assign trial     = {rem_reg, dvd_reg[W-1]};
    assign trial_sub = trial - {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = req.dividend;
            div_next  = req.divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next = trial_sub[W:0];
            end else begin
                rem_next = trial[W:0];
            end
            dvd_next = {dvd_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
    end

    // Remainder is below the divisor, at most 2^W - 1
    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg[W-1:0];

endmodule

>>> hw/rtl/rpt_checker.sv
// Port-level checker for the rotary encoder position tracker, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module rpt_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_position,
    input logic [1:0]         m_active_tier,
    input logic               m_button_pressed
);

    // Handshake terms and the result payload as one word
    logic        s_accept;
    logic        m_stall;
    logic [34:0] m_payload;

    assign s_accept  = s_valid && s_ready;
    assign m_stall   = m_valid && !m_ready;
    assign m_payload = {m_position, m_active_tier, m_button_pressed};

    // A stalled result stays offered
    `RPT_ASSERT(a_m_hold, aclk, aresetn, m_stall |=> m_valid, "result dropped while stalled")

    // A stalled result keeps its payload
    `RPT_ASSERT(a_m_stable, aclk, aresetn, m_stall |=> $stable(m_payload), "stalled result changed")

    // One request at a time: ready drops right after an accept
    `RPT_ASSERT(a_one_at_a_time, aclk, aresetn, s_accept |=> !s_ready, "request accepted while busy")

    // Reset leaves no result pending
    `RPT_ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind rotary_encoder_position_tracker rpt_checker u_rpt_checker (.*);

>>> verif/rotary_encoder_position_tracker_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for rotary_encoder_position_tracker: drives pin-sample and
// reset requests, predicts every result and checks it. Depends on rpt_pkg and the RTL.
module rotary_encoder_position_tracker_tb;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_RESET  = 1'b1;

    localparam longint POS_MAX = 64'sh7FFF_FFFF;
    localparam longint POS_MIN = -64'sh8000_0000;

    typedef struct packed {
        logic        command;
        logic        a_level;
        logic        b_level;
        logic        button_level;
        logic [31:0] now_us;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] position;
        logic [1:0]         tier;
        logic               pressed;
    } result_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PATTERN,
        READY_SPARSE
    } ready_mode_t;

    // DUT signals
    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [rpt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rpt_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_valid        = 1'b0;
    logic                           s_ready;
    logic                           s_command      = 1'b0;
    logic                           s_a_level      = 1'b1;
    logic                           s_b_level      = 1'b1;
    logic                           s_button_level = 1'b1;
    logic [31:0]                    s_now_us       = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic signed [31:0]             m_position;
    logic [1:0]                     m_active_tier;
    logic                           m_button_pressed;

    // Request and expected-result stores
    sample_t sample_queue[$];
    result_t predicted_results[$];
    sample_t req_on_bus;

    // Register shadow
    logic signed [31:0] cfg_min;
    logic signed [31:0] cfg_max;
    logic [30:0]        cfg_step;
    logic               cfg_wrap;
    logic               cfg_reverse;
    logic               cfg_half;
    logic [47:0]        cfg_thresh;
    logic [47:0]        cfg_mult;

    // Tracker state
    logic [1:0]         trk_phase       = 2'd0;
    int                 trk_steps       = 0;
    logic signed [31:0] trk_pos         = '0;
    logic [31:0]        trk_last_detent = '0;
    logic [1:0]         trk_tier        = 2'd0;
    logic               trk_btn_stable  = 1'b1;
    logic               trk_pressed     = 1'b0;
    logic [31:0]        trk_db_start    = '0;
    logic               trk_db_active   = 1'b0;

    // Stimulus generator state
    logic [1:0]  gen_phase = 2'd0;
    logic        gen_btn   = 1'b1;
    logic [31:0] gen_us    = '0;
    int          gen_dir   = 1;

    // Statistics
    int accepted_count = 0;
    int checked_count  = 0;
    int mismatch_count = 0;
    int detent_count   = 0;
    int tier_hits[4]   = '{0, 0, 0, 0};
    int wrap_count     = 0;
    int clamp_count    = 0;
    int btn_changes    = 0;
    int reset_cmds     = 0;
    int settings_count = 0;

    // Sender and receiver pacing
    int          burst_left = 0;
    int          gap_left   = 0;
    ready_mode_t ready_mode = READY_ALWAYS;
    int          mode_left  = 0;
    int          ready_tick = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    rotary_encoder_position_tracker u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_a_level        (s_a_level),
        .s_b_level        (s_b_level),
        .s_button_level   (s_button_level),
        .s_now_us         (s_now_us),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_position       (m_position),
        .m_active_tier    (m_active_tier),
        .m_button_pressed (m_button_pressed)
    );

    // Position of a quadrature phase along the forward Gray sequence 0,1,3,2
    function automatic logic [1:0] gray_rank(input logic [1:0] ph);
        return {ph[1], ph[1] ^ ph[0]};
    endfunction

    // +1 forward, -1 backward, 0 when both channels changed
    function automatic int quad_move(input logic [1:0] from_ph, input logic [1:0] to_ph);
        logic [1:0] d;
        d = gray_rank(to_ph) - gray_rank(from_ph);
        if (d == 2'd1)
            return 1;
        if (d == 2'd3)
            return -1;
        return 0;
    endfunction

    function automatic logic [1:0] quad_advance(input logic [1:0] ph, input int dir);
        logic [1:0] r;
        logic [1:0] step;
        step = dir[1:0];
        r    = gray_rank(ph) + step;
        return {r[1], r[1] ^ r[0]};
    endfunction

    // Detent: pick tier from the interval, scale the step, saturate, fit the range
    task automatic apply_detent(input int dir, input logic [31:0] now);
        logic [31:0] gap_ms;
        logic [15:0] th;
        int unsigned tier;
        longint      mult;
        longint      eff;
        longint      pos;
        longint      lo;
        longint      hi;
        longint      span;
        gap_ms          = (now - trk_last_detent) / rpt_pkg::US_PER_MS;
        trk_last_detent = now;
        tier            = 0;
        mult            = 1;
        for (int k = rpt_pkg::TIER_COUNT - 1; k >= 0; k--) begin
            th = cfg_thresh[16*k +: 16];
            if (tier == 0 && th != 0 && gap_ms < th) begin
                tier = k + 1;
                mult = longint'(cfg_mult[16*k +: 16]);
            end
        end
        trk_tier = tier[1:0];
        eff      = longint'(cfg_step) * mult;
        if (eff > POS_MAX)
            eff = POS_MAX;
        pos = longint'(trk_pos) + ((dir > 0) ? eff : -eff);
        if (pos > POS_MAX)
            pos = POS_MAX;
        if (pos < POS_MIN)
            pos = POS_MIN;
        lo   = longint'(cfg_min);
        hi   = longint'(cfg_max);
        span = hi - lo + 1;
        if (!cfg_wrap || span <= 0) begin
            // clamp; min is tested first, so with inverted limits a position below min settles on min
            if (pos < lo) begin
                pos = lo;
                clamp_count++;
            end else if (pos > hi) begin
                pos = hi;
                clamp_count++;
            end
        end else if (pos > hi) begin
            pos = lo + (pos - lo) % span;
            wrap_count++;
        end else if (pos < lo) begin
            pos = hi - (lo - 1 - pos) % span;
            wrap_count++;
        end
        trk_pos = pos[31:0];
        detent_count++;
        tier_hits[tier]++;
    endtask

    // Expected result of one accepted request; advances the tracker state
    task automatic track_sample(input sample_t req, output result_t res);
        logic [1:0] ph;
        int         move;
        int         need;
        if (req.command == CMD_RESET) begin
            trk_pos  = cfg_min;
            trk_tier = 2'd0;
            reset_cmds++;
        end else begin
            ph = {~req.a_level, ~req.b_level};
            if (ph != trk_phase) begin
                move = quad_move(trk_phase, ph);
                if (move != 0) begin
                    need = cfg_half ? 2 : 4;
                    if (cfg_reverse)
                        move = -move;
                    trk_steps += move;
                    if (trk_steps >= need || trk_steps <= -need) begin
                        move      = (trk_steps > 0) ? 1 : -1;
                        trk_steps = 0;
                        apply_detent(move, req.now_us);
                    end
                end else begin
                    // illegal transition drops the partial count
                    trk_steps = 0;
                end
                trk_phase = ph;
            end
            // first-edge debounce on the button
            if (req.button_level != trk_btn_stable) begin
                if (!trk_db_active) begin
                    trk_db_start  = req.now_us;
                    trk_db_active = 1'b1;
                end else if (req.now_us - trk_db_start >= rpt_pkg::DEBOUNCE_US) begin
                    trk_btn_stable = req.button_level;
                    trk_db_active  = 1'b0;
                    trk_pressed    = ~req.button_level;
                    btn_changes++;
                end
            end else begin
                trk_db_active = 1'b0;
            end
        end
        res.position = trk_pos;
        res.tier     = trk_tier;
        res.pressed  = trk_pressed;
    endtask

    task automatic queue_sample(input logic cmd, input logic [1:0] ph, input logic btn,
                                input logic [31:0] now);
        sample_t req;
        req.command      = cmd;
        req.a_level      = ~ph[1];
        req.b_level      = ~ph[0];
        req.button_level = btn;
        req.now_us       = now;
        sample_queue.push_back(req);
        if (cmd == CMD_SAMPLE)
            gen_phase = ph;
    endtask

    task automatic queue_steps(input int count, input int dir, input int unsigned spacing_us);
        for (int n = 0; n < count; n++) begin
            gen_us += spacing_us;
            queue_sample(CMD_SAMPLE, quad_advance(gen_phase, dir), gen_btn, gen_us);
        end
    endtask

    // Mostly legal rotation at changing speeds, with illegal jumps, idle samples,
    // button activity, reset requests and fully random noise mixed in
    task automatic queue_rotation_run(input int count);
        int          roll;
        int          pace_left;
        int unsigned pace_lo;
        int unsigned pace_hi;
        logic [1:0]  ph;
        logic        btn;
        pace_left = 0;
        pace_lo   = 100;
        pace_hi   = 3000;
        for (int n = 0; n < count; n++) begin
            if (pace_left == 0) begin
                pace_left = $urandom_range(8, 24);
                case ($urandom_range(0, 3))
                    0: begin
                        pace_lo = 100;
                        pace_hi = 3000;
                    end
                    1: begin
                        pace_lo = 10000;
                        pace_hi = 20000;
                    end
                    2: begin
                        pace_lo = 20000;
                        pace_hi = 37000;
                    end
                    default: begin
                        pace_lo = 40000;
                        pace_hi = 400000;
                    end
                endcase
            end
            pace_left--;
            gen_us += $urandom_range(pace_lo, pace_hi);
            if ($urandom_range(0, 24) == 0)
                gen_btn = ~gen_btn;
            btn  = ($urandom_range(0, 32) == 0) ? ~gen_btn : gen_btn;
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                queue_sample(CMD_RESET, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                             gen_us);
            end else if (roll < 7) begin
                gen_us = $urandom();
                queue_sample(CMD_SAMPLE, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                             gen_us);
            end else begin
                if (roll < 11) begin
                    ph = gen_phase ^ 2'b11;
                end else if (roll < 15) begin
                    ph = gen_phase;
                end else begin
                    if (roll < 18)
                        gen_dir = -gen_dir;
                    ph = quad_advance(gen_phase, gen_dir);
                end
                queue_sample(CMD_SAMPLE, ph, btn, gen_us);
            end
        end
    endtask

    task automatic set_reg(input logic [rpt_pkg::CFG_IDX_W-1:0] idx, input logic [47:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            rpt_pkg::REG_MIN_POSITION: cfg_min     = val[31:0];
            rpt_pkg::REG_MAX_POSITION: cfg_max     = val[31:0];
            rpt_pkg::REG_STEP_SIZE:    cfg_step    = val[30:0];
            rpt_pkg::REG_WRAP_ENABLE:  cfg_wrap    = val[0];
            rpt_pkg::REG_REVERSE_DIR:  cfg_reverse = val[0];
            rpt_pkg::REG_HALF_DETENT:  cfg_half    = val[0];
            rpt_pkg::REG_TIER_THRESH:  cfg_thresh  = val;
            rpt_pkg::REG_TIER_MULT:    cfg_mult    = val;
            default: ;
        endcase
    endtask

    // Only called with the block idle
    task automatic write_settings(input longint lo, input longint hi, input longint step,
                                  input logic wrap, input logic rev, input logic half,
                                  input logic [47:0] th, input logic [47:0] mu);
        set_reg(rpt_pkg::REG_MIN_POSITION, {16'h0, lo[31:0]});
        set_reg(rpt_pkg::REG_MAX_POSITION, {16'h0, hi[31:0]});
        set_reg(rpt_pkg::REG_STEP_SIZE,    {17'h0, step[30:0]});
        set_reg(rpt_pkg::REG_WRAP_ENABLE,  {47'h0, wrap});
        set_reg(rpt_pkg::REG_REVERSE_DIR,  {47'h0, rev});
        set_reg(rpt_pkg::REG_HALF_DETENT,  {47'h0, half});
        set_reg(rpt_pkg::REG_TIER_THRESH,  th);
        set_reg(rpt_pkg::REG_TIER_MULT,    mu);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_count++;
    endtask

    // Every request sent and every result returned
    task automatic wait_all_returned();
        do
            @(negedge aclk);
        while (sample_queue.size() != 0 || s_valid || predicted_results.size() != 0);
    endtask

    // Request driver: bursts of random length separated by random gaps
    always @(posedge aclk) begin : request_driver
        result_t want;
        logic    hold;
        logic    launch;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            hold   = s_valid && !s_ready;
            launch = 1'b0;
            if (s_valid && s_ready) begin
                track_sample(req_on_bus, want);
                predicted_results.push_back(want);
                accepted_count++;
            end
            if (!hold) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (sample_queue.size() != 0) begin
                    req_on_bus = sample_queue.pop_front();
                    launch     = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // one burst in four follows on with no gap
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                s_valid <= launch;
                if (launch) begin
                    s_command      <= req_on_bus.command;
                    s_a_level      <= req_on_bus.a_level;
                    s_b_level      <= req_on_bus.b_level;
                    s_button_level <= req_on_bus.button_level;
                    s_now_us       <= req_on_bus.now_us;
                end
            end
        end
    end

    // Result monitor and receiver stall pattern
    always @(posedge aclk) begin : result_monitor
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got.position = m_position;
                got.tier     = m_active_tier;
                got.pressed  = m_button_pressed;
                checked_count++;
                if (predicted_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected result %0d: position %0d tier %0d button %0b",
                                 checked_count, got.position, got.tier, got.pressed);
                end else begin
                    want = predicted_results.pop_front();
                    if (got.position !== want.position || got.tier !== want.tier ||
                        got.pressed !== want.pressed) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("Mismatch at result %0d: expected position %0d tier %0d button %0b",
                                     checked_count, want.position, want.tier, want.pressed);
                            $display("    got position %0d tier %0d button %0b",
                                     got.position, got.tier, got.pressed);
                        end
                    end
                end
            end
            if (mode_left == 0) begin
                ready_mode = ready_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            ready_tick++;
            case (ready_mode)
                READY_ALWAYS:  m_ready <= 1'b1;
                READY_RANDOM:  m_ready <= ($urandom_range(0, 3) != 0);
                READY_PATTERN: m_ready <= ((ready_tick % 5) < 2);
                default:       m_ready <= ((ready_tick % 8) == 0);
            endcase
        end
    end

    // Stimulus phases
    initial begin : stimulus
        longint      lo;
        longint      hi;
        longint      step;
        logic [47:0] th;
        logic [47:0] mu;

        cfg_min     = rpt_pkg::MIN_POS_RESET;
        cfg_max     = rpt_pkg::MAX_POS_RESET;
        cfg_step    = rpt_pkg::STEP_RESET;
        cfg_wrap    = 1'b0;
        cfg_reverse = 1'b0;
        cfg_half    = 1'b0;
        cfg_thresh  = rpt_pkg::THRESH_RESET;
        cfg_mult    = rpt_pkg::MULT_RESET;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, reset settings: fast detent, backward detent with an illegal
        // jump inside, button press and bounce, reset request, timestamp wrap
        queue_steps(4, 1, 1000);
        queue_steps(2, -1, 12000);
        gen_us += 12000;
        queue_sample(CMD_SAMPLE, gen_phase ^ 2'b11, gen_btn, gen_us);
        queue_steps(4, -1, 12000);
        gen_btn = 1'b0;
        gen_us += 1000;
        queue_sample(CMD_SAMPLE, gen_phase, gen_btn, gen_us);
        gen_us += 21000;
        queue_sample(CMD_SAMPLE, gen_phase, gen_btn, gen_us);
        gen_us += 500;
        queue_sample(CMD_SAMPLE, gen_phase, 1'b1, gen_us);
        gen_us += 500;
        queue_sample(CMD_SAMPLE, gen_phase, gen_btn, gen_us);
        queue_sample(CMD_RESET, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), gen_us);
        gen_us = 32'hFFFF_FFFF - 32'd4000;
        queue_steps(4, 1, 1000);
        queue_steps(1, 1, 1);
        queue_steps(3, 1, 2000);
        wait_all_returned();

        // Small wrapping range, two steps per detent
        write_settings(-50, 50, 3, 1'b1, 1'b0, 1'b1,
                       rpt_pkg::THRESH_RESET, rpt_pkg::MULT_RESET);
        queue_rotation_run(100);
        wait_all_returned();

        // Full range, largest step and multipliers: saturation at both ends
        write_settings(POS_MIN, POS_MAX, POS_MAX, 1'b0, 1'b1, 1'b0,
                       48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        queue_rotation_run(60);
        wait_all_returned();

        // Tiny wrapping range, disabled tier and zero multiplier, clock wrap
        write_settings(-7, 9, 1000003, 1'b1, 1'b0, 1'b1,
                       {16'd0, 16'd100, 16'd200}, {16'd7, 16'd0, 16'd3});
        gen_us = 32'hFFFF_FFFF - $urandom_range(0, 200000);
        queue_rotation_run(40);
        // hold off until the pipeline is empty, then carry on with the same settings
        wait_all_returned();
        queue_rotation_run(40);
        wait_all_returned();

        // Inverted limits: wrap behaves as clamp
        write_settings(100, -100, 5, 1'b1, 1'b1, 1'b0,
                       rpt_pkg::THRESH_RESET, rpt_pkg::MULT_RESET);
        queue_rotation_run(60);
        wait_all_returned();

        // Single-value range with wrap
        write_settings(12345, 12345, 1, 1'b1, 1'b0, 1'b0,
                       rpt_pkg::THRESH_RESET, rpt_pkg::MULT_RESET);
        queue_rotation_run(30);
        wait_all_returned();

        // Full range with wrap and large steps
        write_settings(POS_MIN, POS_MAX, 64'h4000_0000, 1'b1, 1'b0, 1'b1,
                       rpt_pkg::THRESH_RESET, rpt_pkg::MULT_RESET);
        queue_rotation_run(40);
        wait_all_returned();

        // Random settings
        for (int r = 0; r < 3; r++) begin
            lo = longint'($signed($urandom()));
            hi = lo + (($urandom_range(0, 3) == 0) ? longint'($urandom())
                                                    : longint'($urandom_range(1, 200)));
            if (hi > POS_MAX)
                hi = POS_MAX;
            step = ($urandom_range(0, 1) == 1) ? longint'($urandom_range(1, 20))
                                               : longint'(($urandom() >> 1) | 1);
            for (int f = 0; f < 3; f++) begin
                th[16*f +: 16] = ($urandom_range(0, 3) == 0) ? 16'd0
                                                            : 16'($urandom_range(1, 300));
                mu[16*f +: 16] = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 60))
                                                             : 16'($urandom_range(0, 65535));
            end
            write_settings(lo, hi, step, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), th, mu);
            queue_rotation_run(50);
            wait_all_returned();
        end

        // Let anything stray show up before judging
        repeat (45) @(posedge aclk);
        $display("Covered %0d requests (%0d reset) under %0d register settings; %0d detents, %s",
                 accepted_count, reset_cmds, settings_count + 1, detent_count,
                 $sformatf("tiers 0/1/2/3 taken %0d/%0d/%0d/%0d times",
                           tier_hits[0], tier_hits[1], tier_hits[2], tier_hits[3]));
        $display("Range fits: %0d wraps, %0d clamps; %0d debounced button changes; %0d mismatches",
                 wrap_count, clamp_count, btn_changes, mismatch_count);
        if (mismatch_count == 0 && predicted_results.size() == 0 &&
            checked_count == accepted_count) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Hang guard
    initial begin : run_limit
        #(5_000_000);
        $display("Timeout: %0d requests queued, %0d results outstanding",
                 sample_queue.size(), predicted_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/rpt_pkg.sv
hw/rtl/rpt_mod_unit.sv
hw/rtl/rotary_encoder_position_tracker.sv
hw/rtl/rpt_checker.sv
verif/rotary_encoder_position_tracker_tb.sv
